/* rtl/core/rcpa_pkg.sv */
// Shared constants, codes, beat types and helpers for the refcounted page allocator.
package rcpa_pkg;

  localparam int NUM_PAGES  = 16384;
  localparam int PAGE_SHIFT = 12;

  localparam int PAGE_IDX_W = $clog2(NUM_PAGES);
  localparam int TOP_W      = $clog2(NUM_PAGES + 1);
  localparam int ADDR_W     = 32;
  localparam int KEND_W     = 27;
  localparam int PA_W       = 26;
  localparam int CNT_W      = 8;
  localparam int FUNC_W     = 3;
  localparam int STAT_W     = 2;
  localparam int MEM_W      = 40;

  localparam logic [MEM_W-1:0] MEM_TOP = MEM_W'(NUM_PAGES) << PAGE_SHIFT;

  // Operation codes
  localparam logic [FUNC_W-1:0] FN_ALLOC = 3'd0;
  localparam logic [FUNC_W-1:0] FN_FREE  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_INC   = 3'd2;
  localparam logic [FUNC_W-1:0] FN_DEC   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_QUERY = 3'd4;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_NONE     = 2'd1;
  localparam logic [STAT_W-1:0] ST_BADFREE  = 2'd2;
  localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [ADDR_W-1:0] phys_address;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [PA_W-1:0]   page_address;
    logic [CNT_W-1:0]  count_value;
  } rsp_t;

  // True when the byte address lies below the top of memory
  function automatic logic in_memory(input logic [ADDR_W-1:0] addr);
    return MEM_W'(addr) < MEM_TOP;
  endfunction

  // Page index of a byte address
  function automatic logic [PAGE_IDX_W-1:0] page_of(input logic [ADDR_W-1:0] addr);
    logic [ADDR_W-1:0] sh;
    sh = addr >> PAGE_SHIFT;
    return sh[PAGE_IDX_W-1:0];
  endfunction

endpackage

/* rtl/core/rcpa_ram.sv */
// Simple dual-port synchronous RAM with registered read.
module rcpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/refcounted_page_allocator.sv */
// Top level of the refcounted page allocator: sequencer, free stack and count memories.
//
// After reset the block sweeps the reference-count memory to zero, one entry per cycle,
// over all NUM_PAGES entries (16384), holding busy high; configuration writes are taken
// during the sweep. Each command is accepted when start is high and busy is low; its
// single result beat is registered out of the execute state, with done high for exactly
// one cycle; the receiver has no way to stall it. No new command is accepted until the
// last one leaves the execute state: the accept reads the count memory and the free stack
// memory, the execute state modifies and writes back, with busy high. The kernel end
// register may be written with cfg_we at any time while no command is in flight.
module refcounted_page_allocator
  import rcpa_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  req_t              req,
  output logic              done,
  output rsp_t              rsp,
  input  logic              cfg_we,
  input  logic [KEND_W-1:0] cfg_data
);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_EXEC} state_t;

  state_t                 state;
  logic [PAGE_IDX_W-1:0]  clr_idx;
  logic [TOP_W-1:0]       stack_top;
  logic [TOP_W-1:0]       top_next;
  logic [KEND_W-1:0]      kernel_end;

  logic [FUNC_W-1:0]      op_func;
  logic [PAGE_IDX_W-1:0]  op_page;
  logic                   op_in_mem;
  logic                   op_bad_free;
  rsp_t                   rsp_next;

  logic                   accept;
  logic                   req_in_mem;
  logic                   req_bad_free;
  logic [TOP_W-1:0]       top_dec;

  logic                   cnt_we;
  logic [PAGE_IDX_W-1:0]  cnt_waddr;
  logic [CNT_W-1:0]       cnt_wdata;
  logic [CNT_W-1:0]       cnt_rdata;
  logic                   stk_we;
  logic [PAGE_IDX_W-1:0]  stk_waddr;
  logic [PAGE_IDX_W-1:0]  stk_rdata;
  logic [PAGE_IDX_W-1:0]  alloc_idx;
  logic [PAGE_IDX_W+PAGE_SHIFT-1:0] pa_wide;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // Check the request address on the accepted beat
  assign req_in_mem   = in_memory(req.phys_address);
  assign req_bad_free = (req.phys_address[PAGE_SHIFT-1:0] != '0) ||
                        (req.phys_address < ADDR_W'(kernel_end)) || !req_in_mem;
  assign top_dec      = stack_top - TOP_W'(1);

  rcpa_ram #(.WIDTH(CNT_W), .DEPTH(NUM_PAGES)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (accept),
    .raddr (page_of(req.phys_address)),
    .rdata (cnt_rdata)
  );

  rcpa_ram #(.WIDTH(PAGE_IDX_W), .DEPTH(NUM_PAGES)) u_stk_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (op_page),
    .re    (accept),
    .raddr (top_dec[PAGE_IDX_W-1:0]),
    .rdata (stk_rdata)
  );

  // Popped entries always hold pushed pages; clamp anything beyond memory to page zero
  assign alloc_idx = ({1'b0, stk_rdata} >= TOP_W'(NUM_PAGES)) ? '0 : stk_rdata;
  assign pa_wide   = {alloc_idx, {PAGE_SHIFT{1'b0}}};

  // Modify the counts and the stack on the execute cycle, or sweep counts to zero
  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = op_page;
    cnt_wdata = '0;
    stk_we    = 1'b0;
    stk_waddr = stack_top[PAGE_IDX_W-1:0];
    top_next  = stack_top;
    rsp_next  = '{status: ST_NONE, page_address: '0, count_value: '0};
    if (state == S_CLEAR) begin
      cnt_we    = 1'b1;
      cnt_waddr = clr_idx;
    end else if (state == S_EXEC) begin
      unique case (op_func) inside
        FN_ALLOC: begin
          if (stack_top != '0) begin
            top_next              = top_dec;
            cnt_we                = 1'b1;
            cnt_waddr             = alloc_idx;
            cnt_wdata             = CNT_W'(1);
            rsp_next.status       = ST_OK;
            rsp_next.page_address = PA_W'(pa_wide);
          end
        end
        FN_FREE: begin
          if (op_bad_free) begin
            rsp_next.status = ST_BADFREE;
          end else if (cnt_rdata > CNT_W'(1)) begin
            cnt_we          = 1'b1;
            cnt_wdata       = cnt_rdata - CNT_W'(1);
            rsp_next.status = ST_OK;
          end else begin
            cnt_we = 1'b1;
            if (stack_top >= TOP_W'(NUM_PAGES)) begin
              rsp_next.status = ST_OVERFLOW;
            end else begin
              stk_we          = 1'b1;
              top_next        = stack_top + TOP_W'(1);
              rsp_next.status = ST_OK;
            end
          end
        end
        FN_INC, FN_DEC, FN_QUERY: begin
          if (op_in_mem) begin
            rsp_next.status = ST_OK;
            if (op_func == FN_INC) begin
              cnt_we    = 1'b1;
              cnt_wdata = (cnt_rdata == '1) ? cnt_rdata : cnt_rdata + CNT_W'(1);
            end else if (op_func == FN_DEC) begin
              cnt_we    = 1'b1;
              cnt_wdata = (cnt_rdata == '0) ? cnt_rdata : cnt_rdata - CNT_W'(1);
            end else begin
              rsp_next.count_value = cnt_rdata;
            end
          end
        end
        default: begin
          rsp_next.status = ST_NONE;
        end
      endcase
    end
  end

  // Sequencer state, stack pointer, config register and registered result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_idx    <= '0;
      stack_top  <= '0;
      kernel_end <= '0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        kernel_end <= cfg_data;
      end
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + PAGE_IDX_W'(1);
          if (clr_idx == PAGE_IDX_W'(NUM_PAGES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            op_func     <= req.func;
            op_page     <= page_of(req.phys_address);
            op_in_mem   <= req_in_mem;
            op_bad_free <= req_bad_free;
            state       <= S_EXEC;
          end
        end
        S_EXEC: begin
          stack_top <= top_next;
          rsp       <= rsp_next;
          done      <= 1'b1;
          state     <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/core/rcpa_checker.sv */
// Port-level checker for the refcounted page allocator and its bind.
module rcpa_checker
  import rcpa_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input req_t              req,
  input logic              done,
  input rsp_t              rsp,
  input logic              cfg_we,
  input logic [KEND_W-1:0] cfg_data
);

  // An accepted command is in execution on the next cycle, with no beat yet
  a_exec_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("busy low or stray result right after accept");

  // Every accepted command yields its result beat when its execute state ends
  a_result_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> ##1 done)
    else $error("missing result beat after accepted command");

  // Result beats are never back to back
  a_beat_spacing: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result beats on consecutive cycles");

  // Only a successful beat carries a page address or a count
  a_payload_ok: assert property (@(posedge clk) disable iff (rst)
    (done && ((rsp.page_address != '0) || (rsp.count_value != '0))) |->
      (rsp.status == ST_OK))
    else $error("nonzero payload on a failed result");

  // Never both a page address and a count
  a_payload_excl: assert property (@(posedge clk) disable iff (rst)
    (done && (rsp.page_address != '0)) |-> (rsp.count_value == '0))
    else $error("page address and count both set");

endmodule

bind refcounted_page_allocator rcpa_checker u_rcpa_checker (.*);
